@@ design/mbps_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Masked byte pattern scanner package
// Shared widths, configuration register indexes and the types that travel
// between the scanner cells, the output queue and the top level.
// ----------------------------------------------------------------------------
package mbps_pkg;

    localparam int BYTE_W          = 8;
    localparam int PAT_BYTES       = 32;
    localparam int CNT_W           = 32;
    localparam int ADDR_W          = 64;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 3;
    localparam int PLEN_W          = 6;
    localparam int MAX_PATTERN_DEF = 32;
    localparam int OUTQ_DEPTH      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_0 = 3'd0,
        CFG_PATTERN_1 = 3'd1,
        CFG_PATTERN_2 = 3'd2,
        CFG_PATTERN_3 = 3'd3,
        CFG_CARE_BITS = 3'd4,
        CFG_PAT_LEN   = 3'd5,
        CFG_SCAN_BASE = 3'd6
    } t_cfg_index;

    // Pattern bytes and their care mask as seen by every cell.
    typedef struct packed {
        logic [PAT_BYTES-1:0][BYTE_W-1:0] pat_bytes;
        logic [PAT_BYTES-1:0]             care_mask;
    } t_pat_cfg;

    // One result word.
    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] addr;
    } t_result;

endpackage
`default_nettype wire

@@ design/mbps_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Scanner cell
// Holds one byte of the window and compares it against the pattern byte that
// lines up with its position for the current pattern length.
// ----------------------------------------------------------------------------
module mbps_cell
    import mbps_pkg::*;
#(
    parameter int LEN_W    = 6,
    parameter int CELL_IDX = 0
) (
    input  wire logic              i_clk,
    input  wire logic              i_shift,
    input  wire logic [BYTE_W-1:0] i_byte,
    input  wire logic [LEN_W-1:0]  i_eff_len,
    input  wire t_pat_cfg          i_pat,
    output logic      [BYTE_W-1:0] o_byte,
    output logic                   o_mismatch
);

    logic [BYTE_W-1:0] r_byte;
    logic [LEN_W-1:0]  pat_idx;
    logic              active;
    logic              in_range;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    // The cell holding the byte of age k faces pattern byte (length - 1 - k).
    always_comb begin
        active   = LEN_W'(CELL_IDX) < i_eff_len;
        pat_idx  = i_eff_len - LEN_W'(CELL_IDX) - LEN_W'(1);
        in_range = 32'(pat_idx) < 32'(PAT_BYTES);
        o_mismatch = active && in_range && i_pat.care_mask[5'(pat_idx)]
                     && (r_byte != i_pat.pat_bytes[5'(pat_idx)]);
    end

    assign o_byte = r_byte;

endmodule
`default_nettype wire

@@ design/mbps_out_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that holds result words until the consumer takes them.
// ----------------------------------------------------------------------------
module mbps_out_fifo
    import mbps_pkg::*;
#(
    parameter int DEPTH = OUTQ_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire t_result                    i_data,
    input  wire logic                       i_stall,
    output logic                            o_valid,
    output t_result                         o_data,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int QCNT_W = $clog2(DEPTH+1);

    t_result              r_mem [DEPTH];
    logic [PTR_W-1:0]     r_wr_ptr;
    logic [PTR_W-1:0]     r_rd_ptr;
    logic [QCNT_W-1:0]    r_count;
    logic                 pop;

    assign o_valid = r_count != '0;
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(pop);
        end
    end

endmodule
`default_nettype wire

@@ design/masked_byte_pattern_scanner.sv @@
`default_nettype none
// Each accepted byte passes the evaluation stage and the result stage into the queue.
// Throughput: one byte per cycle unless stalled; the cells compare the whole window together.
// The input stalls while queued words plus the bytes and words in flight reach 4 slots.
// Reset is synchronous: control state and configuration registers return to their reset
// values; window bytes are not cleared, since the byte count masks stale positions.
// ----------------------------------------------------------------------------
// Masked byte pattern scanner
// Streams bytes through a chain of window cells and reports the address of
// the first wildcard pattern match of each scan, or a not-found word.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner
    import mbps_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [BYTE_W-1:0]     i_data_byte,
    input  wire logic                  i_scan_start,
    input  wire logic                  i_scan_end,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_found,
    output logic      [ADDR_W-1:0]     o_match_address,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int QCNT_W = $clog2(OUTQ_DEPTH + 1);

    // Configuration registers.
    t_pat_cfg            r_pat;
    logic [PLEN_W-1:0]   r_plen;
    logic [ADDR_W-1:0]   r_base;

    // Scan state.
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic                r_fin;
    logic                n_fin;

    // Evaluation stage: the item whose byte just entered the window.
    logic                r_s1_valid;
    logic                r_s1_start;
    logic                r_s1_end;

    // Result stage.
    logic                r_res_valid;
    logic                n_res_valid;
    logic                r_res_found;
    logic [CNT_W-1:0]    r_res_offset;
    logic [CNT_W-1:0]    n_res_offset;

    logic                in_accept;
    logic [PLEN_W:0]     len_ext;
    logic [PLEN_W:0]     len_clip;
    logic [LEN_W-1:0]    eff_len;
    logic [LEN_W-1:0]    len_sub;
    logic [BYTE_W-1:0]   chain_byte [MAX_PATTERN+1];
    logic [MAX_PATTERN-1:0] mismatch;
    logic                all_ok;
    logic [CNT_W-1:0]    base_cnt;
    logic                base_fin;
    logic                proc;
    logic [CNT_W-1:0]    cnt1;
    logic                hit;
    t_result             push_data;
    t_result             head;
    logic [QCNT_W-1:0]   q_count;
    logic [QCNT_W+1:0]   occupancy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_plen <= PLEN_W'(1);
            r_base <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PATTERN_0: r_pat.pat_bytes[7:0]   <= i_cfg_data;
                CFG_PATTERN_1: r_pat.pat_bytes[15:8]  <= i_cfg_data;
                CFG_PATTERN_2: r_pat.pat_bytes[23:16] <= i_cfg_data;
                CFG_PATTERN_3: r_pat.pat_bytes[31:24] <= i_cfg_data;
                CFG_CARE_BITS: r_pat.care_mask        <= i_cfg_data[PAT_BYTES-1:0];
                CFG_PAT_LEN:   r_plen                 <= i_cfg_data[PLEN_W-1:0];
                CFG_SCAN_BASE: r_base                 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Credit check: every word that could still reach the queue has a slot.
    assign occupancy  = (QCNT_W+2)'(q_count) + (QCNT_W+2)'(r_s1_valid)
                        + (QCNT_W+2)'(r_res_valid);
    assign o_in_stall = occupancy >= (QCNT_W+2)'(OUTQ_DEPTH);
    assign in_accept  = i_in_valid && !o_in_stall;

    // A length beyond the window is taken as the window size.
    assign len_ext  = {1'b0, r_plen};
    assign len_clip = (len_ext > (PLEN_W+1)'(MAX_PATTERN)) ? (PLEN_W+1)'(MAX_PATTERN)
                                                           : len_ext;
    assign eff_len  = LEN_W'(len_clip);
    assign len_sub  = (eff_len == '0) ? LEN_W'(1) : eff_len;

    assign chain_byte[0] = i_data_byte;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        mbps_cell #(
            .LEN_W    (LEN_W),
            .CELL_IDX (k)
        ) u_cell (
            .i_clk      (i_clk),
            .i_shift    (in_accept),
            .i_byte     (chain_byte[k]),
            .i_eff_len  (eff_len),
            .i_pat      (r_pat),
            .o_byte     (chain_byte[k+1]),
            .o_mismatch (mismatch[k])
        );
    end

    assign all_ok = ~|mismatch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_start <= i_scan_start;
            r_s1_end   <= i_scan_end;
        end
    end

    // A scan start clears the count and the finished flag before the byte counts.
    always_comb begin
        base_cnt = r_s1_start ? '0 : r_cnt;
        base_fin = r_s1_start ? 1'b0 : r_fin;
        proc     = r_s1_valid && !base_fin;
        cnt1     = (&base_cnt) ? base_cnt : base_cnt + CNT_W'(1);
        hit      = (cnt1 >= CNT_W'(eff_len)) && all_ok;
        n_cnt    = proc ? cnt1 : r_cnt;
        n_fin    = proc ? (hit || r_s1_end) : r_fin;
        n_res_valid  = proc && (hit || r_s1_end);
        n_res_offset = hit ? cnt1 - CNT_W'(len_sub) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_fin       <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_fin       <= n_fin;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_res_valid) begin
            r_res_found  <= hit;
            r_res_offset <= n_res_offset;
        end
    end

    assign push_data.found = r_res_found;
    assign push_data.addr  = r_res_found ? r_base + ADDR_W'(r_res_offset) : '0;

    mbps_out_fifo #(
        .DEPTH (OUTQ_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_res_valid),
        .i_data  (push_data),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (head),
        .o_count (q_count)
    );

    assign o_found         = head.found;
    assign o_match_address = head.addr;

`ifndef SYNTHESIS
    // The credit scheme must leave room for every word that reaches the queue.
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> (q_count < QCNT_W'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    // A result always closes its scan.
    a_result_closes_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_valid |-> r_fin)
        else $error("result given while scan still open");

    // A not-found word carries a zero address.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_address == '0))
        else $error("not-found word with nonzero address");
`endif

endmodule
`default_nettype wire

@@ tb/masked_byte_pattern_scanner_tb.sv @@
// ----------------------------------------------------------------------------
// Masked byte pattern scanner testbench
// Streams scans of bytes into the scanner while both handshakes idle at
// random, predicts the found or not-found word of every scan, and compares
// each word that leaves the block, field by field, against that prediction.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_tb;
    import mbps_pkg::*;

    localparam int RANDOM_ITEMS = 1550;
    localparam int LONG_HOLD    = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int TIMEOUT      = 3_000_000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  i_scan_start = 1'b0;
    logic                  i_scan_end = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_found;
    logic [ADDR_W-1:0]     o_match_address;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Scanner state as predicted by the testbench.
    logic [ADDR_W-1:0]    model_pattern [4];
    logic [PAT_BYTES-1:0] model_care;
    logic [PLEN_W-1:0]    model_len;
    logic [ADDR_W-1:0]    model_base;
    logic [BYTE_W-1:0]    model_window [PAT_BYTES];
    logic [CNT_W-1:0]     model_seen;
    logic                 model_done;

    t_result pending_results [$];
    int      errors = 0;
    int      items_taken = 0;
    int      hold_requests = 0;
    int      holds_served = 0;
    int      rx_wait = 0;
    int      rx_hold = 0;
    bit      tx_no_idle = 1'b0;
    bit      rx_no_idle = 1'b0;

    masked_byte_pattern_scanner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_data_byte     (i_data_byte),
        .i_scan_start    (i_scan_start),
        .i_scan_end      (i_scan_end),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_found         (o_found),
        .o_match_address (o_match_address),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void model_reset();
        for (int w = 0; w < 4; w++) model_pattern[w] = '0;
        model_care = '0;
        model_len  = PLEN_W'(1);
        model_base = '0;
        for (int k = 0; k < PAT_BYTES; k++) model_window[k] = '0;
        model_seen = '0;
        model_done = 1'b0;
    endfunction

    function automatic void model_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_PATTERN_0: model_pattern[0] = data;
            CFG_PATTERN_1: model_pattern[1] = data;
            CFG_PATTERN_2: model_pattern[2] = data;
            CFG_PATTERN_3: model_pattern[3] = data;
            CFG_CARE_BITS: model_care = data[PAT_BYTES-1:0];
            CFG_PAT_LEN:   model_len = data[PLEN_W-1:0];
            CFG_SCAN_BASE: model_base = data;
            default: ;
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] pattern_byte(input int j);
        return model_pattern[j / 8][(j % 8) * 8 +: 8];
    endfunction

    function automatic int active_length();
        return (model_len > PAT_BYTES) ? PAT_BYTES : int'(model_len);
    endfunction

    // Advances the scan by one byte. Returns 1 when the byte produces a word.
    function automatic bit scan_predict(input logic [BYTE_W-1:0] data, input logic start,
                                        input logic stop, output t_result res);
        int                len;
        bit                hit;
        logic [ADDR_W-1:0] offset;
        res   = '0;
        if (start) begin
            for (int k = 0; k < PAT_BYTES; k++) model_window[k] = '0;
            model_seen = '0;
            model_done = 1'b0;
        end
        if (model_done) return 1'b0;
        for (int k = 0; k < PAT_BYTES - 1; k++) model_window[k] = model_window[k + 1];
        model_window[PAT_BYTES - 1] = data;
        if (model_seen != '1) model_seen++;
        len = active_length();
        hit = (model_seen >= len);
        for (int j = 0; j < len; j++) begin
            if (model_care[j] && model_window[PAT_BYTES - len + j] != pattern_byte(j))
                hit = 1'b0;
        end
        if (hit) begin
            // An empty pattern matches at the byte just taken.
            offset = ADDR_W'(model_seen) - ADDR_W'((len == 0) ? 1 : len);
            model_done = 1'b1;
            res.found  = 1'b1;
            res.addr   = model_base + offset;
            return 1'b1;
        end
        if (stop) begin
            model_done = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic push_byte(input logic [BYTE_W-1:0] data, input logic start,
                             input logic stop);
        int      gap;
        t_result res;
        bit      has_word;
        gap = tx_no_idle ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= data;
        i_scan_start <= start;
        i_scan_end   <= stop;
        do @(posedge i_clk); while (o_in_stall);
        has_word = scan_predict(data, start, stop, res);
        if (has_word) pending_results.push_back(res);
        items_taken++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_config(idx, data);
    endtask

    // Waits until every predicted word has arrived, then lets the pipeline
    // settle, since a byte that reports nothing may still be in flight.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_reset_continuation();
        // Nothing is programmed yet: a one-byte wildcard matches the first
        // byte at address zero, and the closing byte is then ignored.
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_exact_match();
        write_reg(CFG_PATTERN_0, 64'h0123_4567_EFBE_ADDE);
        write_reg(CFG_PATTERN_1, '1);
        write_reg(CFG_PATTERN_2, '0);
        write_reg(CFG_PATTERN_3, '1);
        // Bit 31 lies beyond the pattern and must have no effect.
        write_reg(CFG_CARE_BITS, 64'h8000_000F);
        write_reg(CFG_PAT_LEN, 64'd4);
        write_reg(CFG_SCAN_BASE, '1);
        i_cfg_valid <= 1'b0;
        // The match at offset one wraps the address to zero.
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'hDE, 1'b0, 1'b0);
        push_byte(8'hAD, 1'b0, 1'b0);
        push_byte(8'hBE, 1'b0, 1'b0);
        push_byte(8'hEF, 1'b0, 1'b0);
        push_byte(8'h11, 1'b0, 1'b1);
        push_byte(8'hDE, 1'b1, 1'b0);
        push_byte(8'hAD, 1'b0, 1'b0);
        push_byte(8'hBE, 1'b0, 1'b0);
        push_byte(8'hEF, 1'b0, 1'b1);
        // A match that would run past the end of the scan is not found.
        push_byte(8'hDE, 1'b1, 1'b0);
        push_byte(8'hAD, 1'b0, 1'b0);
        push_byte(8'hBE, 1'b0, 1'b1);
        push_byte(8'hFF, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_wildcards_and_length();
        write_reg(CFG_CARE_BITS, 64'h9);
        write_reg(CFG_SCAN_BASE, 64'h0);
        i_cfg_valid <= 1'b0;
        push_byte(8'hDE, 1'b1, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'hEF, 1'b0, 1'b1);
        wait_drained();
        // An empty pattern reports the first byte of every scan.
        write_reg(CFG_PAT_LEN, 64'd0);
        write_reg(CFG_SCAN_BASE, 64'h8000_0000_0000_0000);
        i_cfg_valid <= 1'b0;
        push_byte(8'h55, 1'b1, 1'b0);
        push_byte(8'h66, 1'b0, 1'b1);
        push_byte(8'h77, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        write_reg(CFG_PAT_LEN, 64'd1);
        write_reg(CFG_CARE_BITS, 64'h0);
        i_cfg_valid <= 1'b0;
        // Every byte opens a scan and reports at once, so the result queue
        // fills while the receiver holds off and the input has to stall.
        tx_no_idle = 1'b1;
        hold_requests++;
        repeat (40) push_byte(8'($urandom), 1'b1, 1'($urandom));
        tx_no_idle = 1'b0;
        wait_drained();
    endtask

    task automatic program_random_pattern();
        logic [PAT_BYTES-1:0] care;
        logic [ADDR_W-1:0]    base;
        logic [PLEN_W-1:0]    len;
        case ($urandom_range(0, 7))
            0: len = PLEN_W'(0);
            1: len = PLEN_W'(1);
            2: len = PLEN_W'(PAT_BYTES);
            3: len = PLEN_W'($urandom_range(PAT_BYTES + 1, 63));
            default: len = PLEN_W'($urandom_range(2, 12));
        endcase
        case ($urandom_range(0, 4))
            0: care = '1;
            1: care = '0;
            2: care = $urandom;
            default: care = $urandom | $urandom;
        endcase
        case ($urandom_range(0, 3))
            0: base = '1;
            1: base = '0;
            default: base = {$urandom, $urandom};
        endcase
        write_reg(CFG_PATTERN_0, {$urandom, $urandom});
        write_reg(CFG_PATTERN_1, {$urandom, $urandom});
        write_reg(CFG_PATTERN_2, {$urandom, $urandom});
        write_reg(CFG_PATTERN_3, {$urandom, $urandom});
        // Upper data bits beyond a register's width are dropped by the block.
        write_reg(CFG_CARE_BITS, {($urandom_range(0, 1) ? $urandom : 32'h0), care});
        write_reg(CFG_PAT_LEN, {($urandom_range(0, 1) ? $urandom : 32'h0),
                                26'($urandom), len});
        write_reg(CFG_SCAN_BASE, base);
        if ($urandom_range(0, 5) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_random_scan();
        logic [BYTE_W-1:0] scan_bytes [128];
        int                n;
        int                len;
        int                pos;
        int                kind;
        int                stray;
        bit                narrow;
        len = active_length();
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
        // Bytes drawn from the pattern itself give many partial matches.
        narrow = ($urandom_range(0, 2) == 0) && (len > 0);
        for (int i = 0; i < n; i++) begin
            if (narrow) scan_bytes[i] = pattern_byte($urandom_range(0, len - 1));
            else scan_bytes[i] = 8'($urandom);
        end
        if (len > 0 && len <= n && $urandom_range(0, 3) != 0) begin
            pos = $urandom_range(0, n - len);
            for (int j = 0; j < len; j++) begin
                if (model_care[j]) scan_bytes[pos + j] = pattern_byte(j);
            end
        end
        // Most scans are well formed; a few lose their start or end marker,
        // restart in the middle, or are followed by loose bytes.
        kind  = $urandom_range(0, 11);
        stray = (kind == 9 && n > 2) ? $urandom_range(1, n - 1) : -1;
        for (int i = 0; i < n; i++)
            push_byte(scan_bytes[i], (i == 0 && kind != 10) || i == stray,
                      i == n - 1 && kind != 11);
        if (kind == 8)
            repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0, 1'($urandom));
    endtask

    task automatic test_random_scans();
        int target;
        target = items_taken + RANDOM_ITEMS;
        while (items_taken < target) begin
            program_random_pattern();
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 10)) send_random_scan();
            wait_drained();
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    // Receiver: after each word it waits a drawn number of cycles unless set never to idle, and on
    // request it holds off for a long stretch regardless of traffic.
    always @(posedge i_clk) begin
        if (rx_wait > 0) rx_wait--;
        if (rx_hold > 0) rx_hold--;
        if (hold_requests != holds_served) begin
            holds_served++;
            rx_hold = LONG_HOLD;
        end
        if (o_out_valid && !i_out_stall && !rx_no_idle) rx_wait = $urandom_range(0, 12);
        i_out_stall <= (rx_wait > 0) || (rx_hold > 0);
    end

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected word: found=%0b match_address=%h",
                       o_found, o_match_address);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0b, got %0b", want.found, o_found);
                    errors++;
                end
                if (o_match_address !== want.addr) begin
                    $error("match_address: expected %h, got %h", want.addr, o_match_address);
                    errors++;
                end
            end
        end
    end

    initial begin
        model_reset();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_continuation();
        test_exact_match();
        test_wildcards_and_length();
        test_output_backpressure();
        test_random_scans();
        wait_drained();
        if (errors == 0) begin
            $display("PASS masked_byte_pattern_scanner");
        end else begin
            $display("FAIL masked_byte_pattern_scanner");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT);
        $display("FAIL masked_byte_pattern_scanner");
        $finish;
    end

endmodule

@@ files.f @@
design/mbps_pkg.sv
design/mbps_cell.sv
design/mbps_out_fifo.sv
design/masked_byte_pattern_scanner.sv
tb/masked_byte_pattern_scanner_tb.sv
